// ----- sv/scl_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_pkg
// Types and constants shared by the serial command line parser modules.
// ----------------------------------------------------------------------------
package scl_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int KEY_W      = 48;

   localparam logic [1:0] REG_KEY_READ   = 2'd0;
   localparam logic [1:0] REG_KEY_RENAME = 2'd1;
   localparam logic [1:0] REG_KEY_REMOTE = 2'd2;

   localparam logic [KEY_W-1:0] KEY_READ_RESET   = 48'd38836256195666;
   localparam logic [KEY_W-1:0] KEY_RENAME_RESET = 48'd38840552410689;
   localparam logic [KEY_W-1:0] KEY_REMOTE_RESET = 48'd38772050054479;

   localparam logic [7:0] CHAR_NUL  = 8'd0;
   localparam logic [7:0] CHAR_CR   = 8'd13;
   localparam logic [7:0] CHAR_STAR = 8'd42;

   localparam logic [1:0] TYPE_READ         = 2'd0;
   localparam logic [1:0] TYPE_RENAME       = 2'd1;
   localparam logic [1:0] TYPE_REMOTE       = 2'd2;
   localparam logic [1:0] TYPE_UNIDENTIFIED = 2'd3;

   localparam logic [2:0] HEADER_LEN     = 3'd6;
   localparam logic [2:0] HEADER_LEN_SAT = 3'd7;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_REJECT  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_cr;
      logic       is_star;
   } item_type;

   typedef struct packed {
      logic       is_end;
      logic [1:0] packet_type;
      logic [7:0] payload_byte;
      logic [3:0] payload_index;
      logic       truncated;
   } result_type;

   typedef struct packed {
      logic [KEY_W-1:0] read;
      logic [KEY_W-1:0] rename;
      logic [KEY_W-1:0] remote;
   } keywords_type;

endpackage

// ----- sv/scl_queue.sv -----
// ----------------------------------------------------------------------------
// scl_queue
// Small flip-flop FIFO with registered pointers and occupancy count.
// ----------------------------------------------------------------------------
module scl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/scl_csr.sv -----
// ----------------------------------------------------------------------------
// scl_csr
// Keyword registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module scl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [scl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output scl_pkg::keywords_type          keywords
);

   import scl_pkg::*;

   keywords_type keys_ff, keys_in;
   logic [1:0]   reg_index;
   logic         wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:3];
   assign wr_en     = psel && penable && pwrite && pready;
   assign keywords  = keys_ff;

   always_comb begin
      keys_in = keys_ff;
      prdata  = '0;
      unique case (reg_index)
         REG_KEY_READ: begin
            prdata = CSR_DATA_W'(keys_ff.read);
            if (wr_en) keys_in.read = pwdata[KEY_W-1:0];
         end
         REG_KEY_RENAME: begin
            prdata = CSR_DATA_W'(keys_ff.rename);
            if (wr_en) keys_in.rename = pwdata[KEY_W-1:0];
         end
         REG_KEY_REMOTE: begin
            prdata = CSR_DATA_W'(keys_ff.remote);
            if (wr_en) keys_in.remote = pwdata[KEY_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff.read   <= KEY_READ_RESET;
         keys_ff.rename <= KEY_RENAME_RESET;
         keys_ff.remote <= KEY_REMOTE_RESET;
      end else begin
         keys_ff <= keys_in;
      end
   end

endmodule

// ----- sv/scl_front.sv -----
// ----------------------------------------------------------------------------
// scl_front
// Accepts received bytes, drops zero bytes and queues classified items.
// ----------------------------------------------------------------------------
module scl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [7:0]        rx_byte,
   output logic              full,
   input  logic              item_pop,
   output scl_pkg::item_type item,
   output logic              item_empty
);

   import scl_pkg::*;

   item_type                 class_item;
   logic                     accept;
   logic                     enqueue;
   logic [$bits(item_type)-1:0] item_bits;

   assign accept  = push && !full;
   assign enqueue = accept && (rx_byte != CHAR_NUL);

   always_comb begin
      class_item.data    = rx_byte;
      class_item.is_cr   = (rx_byte == CHAR_CR);
      class_item.is_star = (rx_byte == CHAR_STAR);
   end

   scl_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (2)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enqueue),
      .push_data (class_item),
      .full      (full),
      .pop       (item_pop),
      .pop_data  (item_bits),
      .empty     (item_empty)
   );

   assign item = item_type'(item_bits);

endmodule

// ----- sv/scl_back.sv -----
// ----------------------------------------------------------------------------
// scl_back
// Line parser: header match, payload emission and end-of-line results.
// ----------------------------------------------------------------------------
module scl_back #(
   parameter int LINE_MAX    = 30,
   parameter int PAYLOAD_MAX = 15,
   parameter int HEADER_SCAN = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scl_pkg::keywords_type keywords,
   input  scl_pkg::item_type     item,
   input  logic                  item_empty,
   output logic                  item_pop,
   input  logic                  rsp_pop,
   output scl_pkg::result_type   rsp,
   output logic                  rsp_empty
);

   import scl_pkg::*;

   localparam int LP_W = $clog2(LINE_MAX + 1);
   localparam int PC_W = $clog2(PAYLOAD_MAX + 1);

   phase_type        phase_ff, phase_in;
   logic [LP_W-1:0]  line_pos_ff, line_pos_in;
   logic [KEY_W-1:0] header_ff, header_in;
   logic [2:0]       header_len_ff, header_len_in;
   logic [1:0]       matched_ff, matched_in;
   logic [PC_W-1:0]  count_ff, count_in;
   logic             dropped_ff, dropped_in;

   logic             out_full;
   logic             emit;
   result_type       result;
   logic [31:0]      count_wide;
   logic [31:0]      pos_wide;
   logic [$bits(result_type)-1:0] rsp_bits;

   assign item_pop   = !item_empty && !out_full;
   assign count_wide = 32'(count_ff);
   assign pos_wide   = 32'(line_pos_ff);

   always_comb begin
      phase_in      = phase_ff;
      line_pos_in   = line_pos_ff;
      header_in     = header_ff;
      header_len_in = header_len_ff;
      matched_in    = matched_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      emit          = 1'b0;
      result        = '0;
      if (item_pop) begin
         if (item.is_cr) begin
            emit          = 1'b1;
            result.is_end = 1'b1;
            if (phase_ff == PHASE_PAYLOAD) begin
               result.packet_type   = matched_ff;
               result.payload_index = count_wide[3:0];
               result.truncated     = dropped_ff;
            end else begin
               result.packet_type = TYPE_UNIDENTIFIED;
            end
            phase_in      = PHASE_HEADER;
            line_pos_in   = '0;
            header_in     = '0;
            header_len_in = '0;
            matched_in    = TYPE_UNIDENTIFIED;
            count_in      = '0;
            dropped_in    = 1'b0;
         end else begin
            if (line_pos_ff < LP_W'(LINE_MAX)) begin
               line_pos_in = line_pos_ff + 1'b1;
            end
            unique case (phase_ff)
               PHASE_HEADER: begin
                  if (pos_wide >= 32'(HEADER_SCAN)) begin
                     phase_in = PHASE_REJECT;
                  end else if (item.is_star) begin
                     phase_in = PHASE_REJECT;
                     if (header_len_ff == HEADER_LEN) begin
                        if (header_ff == keywords.read) begin
                           matched_in = TYPE_READ;
                           phase_in   = PHASE_PAYLOAD;
                        end else if (header_ff == keywords.rename) begin
                           matched_in = TYPE_RENAME;
                           phase_in   = PHASE_PAYLOAD;
                        end else if (header_ff == keywords.remote) begin
                           matched_in = TYPE_REMOTE;
                           phase_in   = PHASE_PAYLOAD;
                        end
                     end
                  end else begin
                     header_in = {header_ff[KEY_W-9:0], item.data};
                     if (header_len_ff < HEADER_LEN_SAT) begin
                        header_len_in = header_len_ff + 1'b1;
                     end
                  end
               end
               PHASE_PAYLOAD: begin
                  if (line_pos_ff >= LP_W'(LINE_MAX) ||
                      count_ff >= PC_W'(PAYLOAD_MAX)) begin
                     dropped_in = 1'b1;
                  end else begin
                     emit                 = 1'b1;
                     result.packet_type   = matched_ff;
                     result.payload_byte  = item.data;
                     result.payload_index = count_wide[3:0];
                     count_in             = count_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = PHASE_REJECT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         line_pos_ff   <= '0;
         header_ff     <= '0;
         header_len_ff <= '0;
         matched_ff    <= TYPE_UNIDENTIFIED;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         line_pos_ff   <= line_pos_in;
         header_ff     <= header_in;
         header_len_ff <= header_len_in;
         matched_ff    <= matched_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
      end
   end

   scl_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp = result_type'(rsp_bits);

endmodule

// ----- sv/serial_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser
// Frames received serial bytes into lines ending in carriage return, matches
// a six-character header against three keyword registers and reports payload
// bytes and an end-of-line transaction per line.
//
// Input channel: drive req_rx_byte with push; a transaction is taken when
// push is high and full is low. Zero bytes are taken and discarded.
// Result channel: while empty is low the oldest result sits on the rsp_
// ports; pop with empty low takes it.
// Configuration: keyword registers at byte addresses 0, 8 and 16; the user
// must see that they are written only while the parser is idle, which the
// block itself does not enforce. A taken byte is registered in the item
// queue; the line parser pops it and puts its result into the result queue.
// Throughput: one byte per cycle while the result queue is not full; the
// two-entry item queue and two-entry result queue decouple the sides.
// When pop is held low, the result queue fills, the parser holds, and full
// rises once the item queue is full as well; nothing is lost.
// Reset clears both queues and the line state and restores the keywords.
// ----------------------------------------------------------------------------
module serial_command_line_parser #(
   parameter int LINE_MAX    = 30,
   parameter int PAYLOAD_MAX = 15,
   parameter int HEADER_SCAN = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [7:0]                     req_rx_byte,
   output logic                           full,
   output logic                           empty,
   input  logic                           pop,
   output logic                           rsp_is_end,
   output logic [1:0]                     rsp_packet_type,
   output logic [7:0]                     rsp_payload_byte,
   output logic [3:0]                     rsp_payload_index,
   output logic                           rsp_truncated,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [scl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import scl_pkg::*;

   keywords_type keywords;
   item_type     item;
   logic         item_empty;
   logic         item_pop;
   result_type   rsp;

   scl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .keywords (keywords)
   );

   scl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rx_byte    (req_rx_byte),
      .full       (full),
      .item_pop   (item_pop),
      .item       (item),
      .item_empty (item_empty)
   );

   scl_back #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .HEADER_SCAN (HEADER_SCAN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .keywords   (keywords),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp_pop    (pop),
      .rsp        (rsp),
      .rsp_empty  (empty)
   );

   assign rsp_is_end        = rsp.is_end;
   assign rsp_packet_type   = rsp.packet_type;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_truncated     = rsp.truncated;

endmodule

// ----- sim/serial_command_line_parser_tb.sv -----
// ----------------------------------------------------------------------------
// serial_command_line_parser_tb
// Self-checking bench for the serial command line parser. A short table of
// lines (empty line, zero byte, read and remote packets, bare '*') runs
// first. Random lines follow: well-formed packets, corrupted, short and long
// headers, lines without '*', truncated payloads and noise. Each phase after
// the first loads new keywords through the register port, extremes and equal
// keywords included, and reads them back. A line model predicts every result
// transaction, and results are compared in order under random idling on
// both channels.
// ----------------------------------------------------------------------------
module serial_command_line_parser_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import scl_pkg::*;

   localparam int LINE_MAX       = 30;
   localparam int PAYLOAD_MAX    = 15;
   localparam int HEADER_SCAN    = 10;
   localparam int HALF_PERIOD    = 6;
   localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 190;
   localparam int HOLD_CYCLES    = 64;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_CYCLES = 200_000;

   typedef struct packed {
      logic [7:0] rx;
      bit         typed;
      result_type want;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;
   localparam result_type END_UNIDENTIFIED = '{1'b1, TYPE_UNIDENTIFIED, 8'h00, 4'd0, 1'b0};

   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{CHAR_CR,   1'b1, END_UNIDENTIFIED},
      '{CHAR_NUL,  1'b0, NO_RESULT},
      '{"#",       1'b0, NO_RESULT},
      '{"R",       1'b0, NO_RESULT},
      '{"E",       1'b0, NO_RESULT},
      '{"A",       1'b0, NO_RESULT},
      '{"D",       1'b0, NO_RESULT},
      '{"R",       1'b0, NO_RESULT},
      '{CHAR_STAR, 1'b0, NO_RESULT},
      '{"A",       1'b0, NO_RESULT},
      '{8'hFF,     1'b0, NO_RESULT},
      '{CHAR_STAR, 1'b0, NO_RESULT},
      '{CHAR_CR,   1'b1, '{1'b1, TYPE_READ, 8'h00, 4'd3, 1'b0}},
      '{CHAR_STAR, 1'b0, NO_RESULT},
      '{CHAR_CR,   1'b1, END_UNIDENTIFIED},
      '{"#",       1'b0, NO_RESULT},
      '{"C",       1'b0, NO_RESULT},
      '{"R",       1'b0, NO_RESULT},
      '{"E",       1'b0, NO_RESULT},
      '{"M",       1'b0, NO_RESULT},
      '{"O",       1'b0, NO_RESULT},
      '{CHAR_STAR, 1'b0, NO_RESULT},
      '{8'h80,     1'b0, NO_RESULT},
      '{CHAR_CR,   1'b1, '{1'b1, TYPE_REMOTE, 8'h00, 4'd1, 1'b0}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic [7:0]            req_rx_byte = '0;
   logic                  full;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  rsp_is_end;
   logic [1:0]            rsp_packet_type;
   logic [7:0]            rsp_payload_byte;
   logic [3:0]            rsp_payload_index;
   logic                  rsp_truncated;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   keywords_type     keys;
   logic [4:0]       line_pos;
   logic [KEY_W-1:0] hdr_bytes;
   logic [2:0]       hdr_len;
   phase_type        line_phase;
   logic [1:0]       line_type;
   int               payload_cnt;
   bit               drop_seen;

   result_type results_due [$];
   int         mismatches = 0;
   int         items_sent = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         hold_left = 0;
   bit         hold_req = 1'b0;

   serial_command_line_parser #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .HEADER_SCAN (HEADER_SCAN)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .req_rx_byte       (req_rx_byte),
      .full              (full),
      .empty             (empty),
      .pop               (pop),
      .rsp_is_end        (rsp_is_end),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_truncated     (rsp_truncated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   task automatic note_mismatch(input string text);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s", text);
      end
   endtask

   task automatic clear_line_state();
      line_pos    = '0;
      hdr_bytes   = '0;
      hdr_len     = '0;
      line_phase  = PHASE_HEADER;
      line_type   = TYPE_UNIDENTIFIED;
      payload_cnt = 0;
      drop_seen   = 1'b0;
   endtask

   task automatic parse_rx_byte(input logic [7:0] b, output bit produced,
                                output result_type r);
      int pos;
      produced = 1'b0;
      r = NO_RESULT;
      if (b == CHAR_NUL) begin
         return;
      end
      if (b == CHAR_CR) begin
         produced = 1'b1;
         if (line_phase == PHASE_PAYLOAD) begin
            r = '{1'b1, line_type, 8'h00, 4'(payload_cnt), drop_seen};
         end else begin
            r = END_UNIDENTIFIED;
         end
         clear_line_state();
         return;
      end
      pos = int'(line_pos);
      if (line_pos < LINE_MAX) begin
         line_pos++;
      end
      case (line_phase)
         PHASE_HEADER: begin
            if (pos >= HEADER_SCAN) begin
               line_phase = PHASE_REJECT;
            end else if (b == CHAR_STAR) begin
               line_phase = PHASE_REJECT;
               if (hdr_len == HEADER_LEN) begin
                  if (hdr_bytes == keys.read) begin
                     line_type  = TYPE_READ;
                     line_phase = PHASE_PAYLOAD;
                  end else if (hdr_bytes == keys.rename) begin
                     line_type  = TYPE_RENAME;
                     line_phase = PHASE_PAYLOAD;
                  end else if (hdr_bytes == keys.remote) begin
                     line_type  = TYPE_REMOTE;
                     line_phase = PHASE_PAYLOAD;
                  end
               end
            end else begin
               hdr_bytes = {hdr_bytes[KEY_W-9:0], b};
               if (hdr_len < HEADER_LEN_SAT) begin
                  hdr_len++;
               end
            end
         end
         PHASE_PAYLOAD: begin
            if (pos >= LINE_MAX || payload_cnt >= PAYLOAD_MAX) begin
               drop_seen = 1'b1;
            end else begin
               produced = 1'b1;
               r = '{1'b0, line_type, b, 4'(payload_cnt), 1'b0};
               payload_cnt++;
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [7:0] header_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_CR || c == CHAR_STAR);
      return c;
   endfunction

   function automatic logic [7:0] payload_char();
      int roll;
      roll = $urandom_range(63);
      if (roll < 2) begin
         return CHAR_NUL;
      end
      if (roll < 6) begin
         return CHAR_STAR;
      end
      return header_char();
   endfunction

   function automatic logic [KEY_W-1:0] rand_keyword();
      logic [KEY_W-1:0] key;
      key = '0;
      for (int i = 0; i < HEADER_LEN; i++) begin
         key = {key[KEY_W-9:0], header_char()};
      end
      return key;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input result_type want = NO_RESULT);
      bit         produced;
      result_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            push = 1'b0;
            req_rx_byte = 8'($urandom);
         end
      end
      @(negedge clock);
      push = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (full);
      parse_rx_byte(b, produced, predicted);
      if (produced) begin
         results_due.push_back(typed ? want : predicted);
      end
      if (b != CHAR_NUL) begin
         items_sent++;
      end
   endtask

   task automatic send_line();
      logic [KEY_W-1:0] key;
      int               kind;
      int               variant;
      int               len;
      int               idx;
      kind = $urandom_range(99);
      case ($urandom_range(2))
         0: key = keys.read;
         1: key = keys.rename;
         default: key = keys.remote;
      endcase
      if (kind < 80) begin
         // 0: well formed, 1: corrupted byte, 2: short header, 3: long header
         variant = (kind < 60) ? 0 : $urandom_range(1, 3);
         if (variant == 1) begin
            idx = $urandom_range(5);
            key[8*idx +: 8] = header_char();
         end
         if (variant == 3) begin
            send_byte(header_char());
         end
         for (int i = 5; i >= ((variant == 2) ? 1 : 0); i--) begin
            send_byte(key[8*i +: 8]);
         end
         send_byte(CHAR_STAR);
         if (variant != 0) begin
            len = $urandom_range(0, 4);
         end else if ($urandom_range(4) == 0) begin
            len = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 9);
         end else begin
            len = $urandom_range(0, PAYLOAD_MAX);
         end
         repeat (len) send_byte(payload_char());
      end else if (kind < 88) begin
         repeat ($urandom_range(1, LINE_MAX + 6)) send_byte(header_char());
      end else begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end
      send_byte(CHAR_CR);
   endtask

   task automatic wait_parser_idle();
      @(negedge clock);
      push = 1'b0;
      req_rx_byte = '0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [KEY_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 3'b000};
      pwdata  = {16'($urandom), value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic check_register(input logic [1:0] idx, input logic [KEY_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 3'b000};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== CSR_DATA_W'(want)) begin
         note_mismatch($sformatf("register %0d read: expected %h, got %h",
                                 idx, CSR_DATA_W'(want), got));
      end
   endtask

   task automatic check_all_registers();
      check_register(REG_KEY_READ, keys.read);
      check_register(REG_KEY_RENAME, keys.rename);
      check_register(REG_KEY_REMOTE, keys.remote);
   endtask

   task automatic write_keywords(input keywords_type k);
      csr_write(REG_KEY_READ, k.read);
      csr_write(REG_KEY_RENAME, k.rename);
      csr_write(REG_KEY_REMOTE, k.remote);
      keys = k;
      check_all_registers();
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         pop = 1'b0;
         hold_left--;
      end else begin
         pop = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && pop && !empty) begin
         got = {rsp_is_end, rsp_packet_type, rsp_payload_byte, rsp_payload_index,
                rsp_truncated};
         if (results_due.size() == 0) begin
            note_mismatch($sformatf({"unexpected result: end %0d type %0d byte %h ",
                                     "index %0d trunc %0d"},
                                    got.is_end, got.packet_type, got.payload_byte,
                                    got.payload_index, got.truncated));
         end else begin
            want = results_due.pop_front();
            if (got !== want) begin
               note_mismatch($sformatf({"result mismatch: expected end %0d type %0d byte %h ",
                                        "index %0d trunc %0d, got end %0d type %0d byte %h ",
                                        "index %0d trunc %0d"},
                                       want.is_end, want.packet_type, want.payload_byte,
                                       want.payload_index, want.truncated,
                                       got.is_end, got.packet_type, got.payload_byte,
                                       got.payload_index, got.truncated));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("FAILURE");
      $finish;
   end

   initial begin
      keywords_type k;
      int           goal;
      bit           paused;
      keys = '{KEY_READ_RESET, KEY_RENAME_RESET, KEY_REMOTE_RESET};
      clear_line_state();
      repeat (4) @(negedge clock);
      reset = 1'b0;
      check_all_registers();

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 55;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 55;
            end
            default: begin
               idle_pct  = 30;
               stall_pct = 30;
            end
         endcase
         if (ph > 0) begin
            wait_parser_idle();
            case (ph)
               1: k = '{rand_keyword(), rand_keyword(), rand_keyword()};
               2: begin
                  k.read   = rand_keyword();
                  k.rename = k.read;
                  k.remote = k.read;
               end
               3: k = '{{KEY_W{1'b0}}, {KEY_W{1'b1}}, rand_keyword()};
               4: begin
                  k.read   = rand_keyword();
                  k.rename = rand_keyword();
                  k.remote = k.rename;
               end
               default: k = '{KEY_READ_RESET, KEY_RENAME_RESET, KEY_REMOTE_RESET};
            endcase
            write_keywords(k);
         end
         // hold the result side off while lines keep coming in
         if (ph == 2) begin
            hold_req = 1'b1;
         end
         goal   = items_sent + PHASE_ITEMS;
         paused = 1'b0;
         while (items_sent < goal) begin
            send_line();
            if (!paused && items_sent >= goal - PHASE_ITEMS / 2) begin
               wait_parser_idle();
               paused = 1'b1;
            end
         end
      end

      wait_parser_idle();
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
